@@ hdl/pbsd_pkg.sv @@
// Shared types, constants and exp tables for the prior box score decode block.
`timescale 1ns / 1ps
`default_nettype none
package pbsd_pkg;

    localparam int CLASS_W     = 7;
    localparam int SCORE_W     = 16;
    localparam int DELTA_W     = 16;
    localparam int ANCHOR_W    = 16;
    localparam int INDEX_W     = 15;
    localparam int IMG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 160;
    localparam int M_TDATA_W   = 88;
    localparam int NUM_CLASSES_DEF = 81;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_CX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_CY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_H     = 3'd6;

    localparam logic MODE_SCORE = 1'b0;
    localparam logic MODE_BOX   = 1'b1;

    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [SCORE_W-1:0]  best;
        logic [DELTA_W-1:0]  dcx;
        logic [DELTA_W-1:0]  dcy;
        logic [DELTA_W-1:0]  dw;
        logic [DELTA_W-1:0]  dh;
        logic [ANCHOR_W-1:0] acx;
        logic [ANCHOR_W-1:0] acy;
        logic [ANCHOR_W-1:0] aw;
        logic [ANCHOR_W-1:0] ah;
        logic [INDEX_W-1:0]  idx;
    } job_t;

    typedef struct packed {
        logic [15:0]      var_cx;
        logic [15:0]      var_cy;
        logic [15:0]      var_w;
        logic [15:0]      var_h;
        logic [IMG_W-1:0] img_w;
        logic [IMG_W-1:0] img_h;
    } geom_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_FIN, ST_OUT
    } back_state_t;

    // exp(n - 8) in Q16 for n = 0 .. 15
    function automatic logic [26:0] exp_int(input logic [3:0] n);
        logic [26:0] r;
        case (n)
            4'd0:  r = 27'd22;
            4'd1:  r = 27'd60;
            4'd2:  r = 27'd162;
            4'd3:  r = 27'd442;
            4'd4:  r = 27'd1200;
            4'd5:  r = 27'd3263;
            4'd6:  r = 27'd8869;
            4'd7:  r = 27'd24110;
            4'd8:  r = 27'd65536;
            4'd9:  r = 27'd178145;
            4'd10: r = 27'd484249;
            4'd11: r = 27'd1316326;
            4'd12: r = 27'd3578144;
            4'd13: r = 27'd9726405;
            4'd14: r = 27'd26439109;
            default: r = 27'd71868951;
        endcase
        return r;
    endfunction

    // exp(k/16) in Q16
    function automatic logic [17:0] exp_frac(input logic [3:0] k);
        logic [17:0] r;
        case (k)
            4'd0:  r = 18'd65536;
            4'd1:  r = 18'd69763;
            4'd2:  r = 18'd74262;
            4'd3:  r = 18'd79052;
            4'd4:  r = 18'd84150;
            4'd5:  r = 18'd89577;
            4'd6:  r = 18'd95354;
            4'd7:  r = 18'd101504;
            4'd8:  r = 18'd108051;
            4'd9:  r = 18'd115019;
            4'd10: r = 18'd122437;
            4'd11: r = 18'd130334;
            4'd12: r = 18'd138740;
            4'd13: r = 18'd147688;
            4'd14: r = 18'd157213;
            default: r = 18'd167352;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/prior_box_score_decode.sv @@
// Top level: configuration registers, front end, job queue and decode back end.
// Requests are taken one per cycle while the job queue has a free slot.
// A qualifying box result is decoded once the back end takes its job from the queue:
// each axis runs eight products on one shared multiplier and a clip step, then the
// result is presented; the next job is taken only after m_tready accepts the result.
// Synchronous active-low reset clears score tracking, queue, sequencer and registers.
`timescale 1ns / 1ps
`default_nettype none
module prior_box_score_decode #(
    parameter int NUM_CLASSES = pbsd_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [pbsd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [pbsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // class_score, delta_cx, delta_cy, delta_w, delta_h, anchor_cx, anchor_cy,
    // anchor_w, anchor_h, anchor_index
    input  wire logic [pbsd_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // class_id, best_confidence, left_x, top_y, box_width, box_height, source_index
    output logic [pbsd_pkg::M_TDATA_W-1:0]         m_tdata
);
    import pbsd_pkg::*;

    logic [15:0] thr_reg;
    geom_cfg_t   cfg_reg;
    job_t        front_job, head_job;
    logic        job_push, q_pop, q_empty, q_full, in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= 16'd32768;
            cfg_reg.var_cx <= 16'd6554;
            cfg_reg.var_cy <= 16'd6554;
            cfg_reg.var_w  <= 16'd13107;
            cfg_reg.var_h  <= 16'd13107;
            cfg_reg.img_w  <= IMG_W'(640);
            cfg_reg.img_h  <= IMG_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_THRESHOLD: thr_reg        <= cfg_wdata;
                REG_VAR_CX:    cfg_reg.var_cx <= cfg_wdata;
                REG_VAR_CY:    cfg_reg.var_cy <= cfg_wdata;
                REG_VAR_W:     cfg_reg.var_w  <= cfg_wdata;
                REG_VAR_H:     cfg_reg.var_h  <= cfg_wdata;
                REG_IMG_W:     cfg_reg.img_w  <= cfg_wdata[IMG_W-1:0];
                REG_IMG_H:     cfg_reg.img_h  <= cfg_wdata[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    pbsd_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_mode   (s_tuser[0]),
        .in_data   (s_tdata),
        .threshold (thr_reg),
        .job       (front_job),
        .job_push  (job_push)
    );

    pbsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    pbsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

@@ hdl/pbsd_front.sv @@
// Front end: accepts score and box requests, tracks the best class, queues decode jobs.
`timescale 1ns / 1ps
`default_nettype none
module pbsd_front #(
    parameter int NUM_CLASSES = pbsd_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_fire,
    input  wire logic                          in_mode,
    input  wire logic [pbsd_pkg::S_TDATA_W-1:0] in_data,
    input  wire logic [15:0]                   threshold,
    output pbsd_pkg::job_t                     job,
    output logic                               job_push
);
    import pbsd_pkg::*;

    localparam logic [CLASS_W-1:0] NCLS = CLASS_W'(NUM_CLASSES);

    logic [CLASS_W-1:0] count_reg, count_next;
    logic [SCORE_W-1:0] best_reg, best_next;
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic [SCORE_W-1:0] score;

    assign score = in_data[15:0];

    always_comb begin
        count_next = count_reg;
        best_next  = best_reg;
        cls_next   = cls_reg;
        job_push   = 1'b0;
        if (in_fire) begin
            if (in_mode == MODE_BOX) begin
                count_next = '0;
                best_next  = '0;
                cls_next   = '0;
                job_push   = best_reg > threshold;
            end else if (count_reg < NCLS) begin
                // first non-background score always seeds the maximum
                if (count_reg == CLASS_W'(1) || (count_reg > CLASS_W'(1) && score > best_reg)) begin
                    best_next = score;
                    cls_next  = count_reg - CLASS_W'(1);
                end
                count_next = count_reg + CLASS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            best_reg  <= '0;
            cls_reg   <= '0;
        end else begin
            count_reg <= count_next;
            best_reg  <= best_next;
            cls_reg   <= cls_next;
        end
    end

    always_comb begin
        job.cls  = cls_reg;
        job.best = best_reg;
        job.dcx  = in_data[31:16];
        job.dcy  = in_data[47:32];
        job.dw   = in_data[63:48];
        job.dh   = in_data[79:64];
        job.acx  = in_data[95:80];
        job.acy  = in_data[111:96];
        job.aw   = in_data[127:112];
        job.ah   = in_data[143:128];
        job.idx  = in_data[158:144];
    end

endmodule
`default_nettype wire

@@ hdl/pbsd_queue.sv @@
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pbsd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire pbsd_pkg::job_t push_job,
    input  wire logic          pop,
    output pbsd_pkg::job_t     head_job,
    output logic               empty,
    output logic               full
);
    import pbsd_pkg::*;

    job_t       mem [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] fill_reg;

    assign empty    = (fill_reg == 2'd0);
    assign full     = (fill_reg == 2'd2);
    assign head_job = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

@@ hdl/pbsd_back.sv @@
// Back end: sequential box decode on one shared multiplier, result register.
`timescale 1ns / 1ps
`default_nettype none
module pbsd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pbsd_pkg::geom_cfg_t           cfg,
    input  wire pbsd_pkg::job_t                head_job,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pbsd_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pbsd_pkg::*;

    back_state_t state_reg, state_next;
    logic        axis_reg, axis_next;
    job_t        job_reg;

    logic signed [52:0] prod_reg, prod_next;
    logic signed [33:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [21:0] cen_reg;
    logic signed [30:0] hi_reg;
    logic [16:0]        poly_reg;
    logic [27:0]        pa_reg;
    logic [11:0]        lo_x_reg, lo_y_reg;
    logic [12:0]        ext_x_reg, ext_y_reg;

    logic [15:0]        ac, asz, vc, vs;
    logic signed [15:0] dc, ds, ew;
    logic [IMG_W-1:0]   img_raw, img;
    logic [27:0]        lim;
    logic [15:0]        eidx;
    logic [11:0]        rq;
    logic [23:0]        rq_sq;
    logic [29:0]        sz;
    logic signed [30:0] lo_pos;
    logic [27:0]        clip_v, diff;
    logic [12:0]        ext_v;

    // per-axis operand selection
    always_comb begin
        ac      = axis_reg ? job_reg.acy : job_reg.acx;
        asz     = axis_reg ? job_reg.ah  : job_reg.aw;
        dc      = axis_reg ? job_reg.dcy : job_reg.dcx;
        ds      = axis_reg ? job_reg.dh  : job_reg.dw;
        vc      = axis_reg ? cfg.var_cy  : cfg.var_cx;
        vs      = axis_reg ? cfg.var_h   : cfg.var_w;
        img_raw = axis_reg ? cfg.img_h   : cfg.img_w;
        if (img_raw == '0)                 img = IMG_W'(1);
        else if (img_raw > IMG_W'(4096))   img = IMG_W'(4096);
        else                               img = img_raw;
        lim = {img[11:0] - 12'd1, 16'd0} | ((img == IMG_W'(4096)) ? 28'hFFF0000 : 28'd0);
    end

    always_comb begin
        ew     = prod_reg[31:16];
        eidx   = {~ew[15], ew[14:0]};
        rq     = {eidx[7:0], 4'd0};
        rq_sq  = rq * rq;
        sz     = prod_reg[45:16];
        lo_pos = 31'(cen_reg) - 31'({1'b0, sz[29:1]});
        if (prod_reg < 0)                       clip_v = '0;
        else if (prod_reg > $signed({25'd0, lim})) clip_v = lim;
        else                                    clip_v = prod_reg[27:0];
        diff  = clip_v - pa_reg;
        ext_v = {1'b0, diff[27:16]} + 13'd1;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_M1: begin mul_a = 34'({1'b0, vc});        mul_b = 19'(dc); end
            ST_M2: begin mul_a = prod_reg[33:0];         mul_b = 19'({1'b0, asz}); end
            ST_M3: begin mul_a = 34'({1'b0, vs});        mul_b = 19'(ds); end
            ST_M4: begin mul_a = 34'({1'b0, exp_int(eidx[15:12])});
                         mul_b = 19'({1'b0, exp_frac(eidx[11:8])}); end
            ST_M5: begin mul_a = 34'({1'b0, prod_reg[44:16]}); mul_b = 19'({1'b0, poly_reg}); end
            ST_M6: begin mul_a = 34'({1'b0, prod_reg[45:16]}); mul_b = 19'({1'b0, asz}); end
            ST_M7: begin mul_a = 34'(lo_pos);            mul_b = 19'({1'b0, img}); end
            ST_M8: begin mul_a = 34'(hi_reg);            mul_b = 19'({1'b0, img}); end
            default: ;
        endcase
        prod_next = 53'(mul_a * mul_b);
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        q_pop      = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (!q_empty) begin
                q_pop      = 1'b1;
                axis_next  = 1'b0;
                state_next = ST_M1;
            end
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_M5;
            ST_M5: state_next = ST_M6;
            ST_M6: state_next = ST_M7;
            ST_M7: state_next = ST_M8;
            ST_M8: state_next = ST_FIN;
            ST_FIN: begin
                if (axis_reg) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next  = 1'b1;
                    state_next = ST_M1;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (q_pop) job_reg <= head_job;
        if (state_reg == ST_M3) cen_reg <= 22'({6'd0, ac}) + 22'(prod_reg >>> 28);
        if (state_reg == ST_M4) poly_reg <= 17'd65536 + 17'(rq) + 17'(rq_sq[23:17]);
        if (state_reg == ST_M7) hi_reg <= 31'(cen_reg) + 31'({1'b0, sz[29:1]});
        if (state_reg == ST_M8) pa_reg <= clip_v;
        if (state_reg == ST_FIN) begin
            if (axis_reg) begin
                lo_y_reg  <= pa_reg[27:16];
                ext_y_reg <= ext_v;
            end else begin
                lo_x_reg  <= pa_reg[27:16];
                ext_x_reg <= ext_v;
            end
        end
    end

    assign m_tdata = {job_reg.idx, ext_y_reg, ext_x_reg, lo_y_reg, lo_x_reg,
                      job_reg.best, job_reg.cls};

endmodule
`default_nettype wire

@@ dv/tb_prior_box_score_decode.sv @@
// Testbench for the prior box score decode block: directed and random priors checked against a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_prior_box_score_decode;
    import pbsd_pkg::*;

    typedef struct {
        logic [6:0]  cls;
        logic [15:0] best;
        logic [11:0] lx;
        logic [11:0] ty;
        logic [12:0] bw;
        logic [12:0] bh;
        logic [14:0] idx;
    } detection_t;

    class detection_board;
        detection_t pending[$];
        int errors;
        logic [15:0] thresh, vcx, vcy, vw, vh;
        logic [12:0] imw, imh;
        int unsigned seen, best_score, best_cls;

        function void reset_state();
            thresh = 16'd32768; vcx = 16'd6554; vcy = 16'd6554;
            vw = 16'd13107; vh = 16'd13107; imw = 13'd640; imh = 13'd480;
            seen = 0; best_score = 0; best_cls = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] a, logic [15:0] d);
            case (a)
                REG_THRESHOLD: thresh = d;
                REG_VAR_CX:    vcx = d;
                REG_VAR_CY:    vcy = d;
                REG_VAR_W:     vw = d;
                REG_VAR_H:     vh = d;
                REG_IMG_W:     imw = d[12:0];
                REG_IMG_H:     imh = d[12:0];
                default: ;
            endcase
        endfunction

        function longint fdiv(longint x, int s);
            return x >>> s;
        endfunction

        function longint exp_fixed(longint e);
            longint unsigned ti[16], tf[16], v, poly;
            int unsigned ix, rq;
            ti = '{22, 60, 162, 442, 1200, 3263, 8869, 24110, 65536, 178145, 484249,
                   1316326, 3578144, 9726405, 26439109, 71868951};
            tf = '{65536, 69763, 74262, 79052, 84150, 89577, 95354, 101504, 108051,
                   115019, 122437, 130334, 138740, 147688, 157213, 167352};
            if (e < -32768) e = -32768;
            if (e > 32767) e = 32767;
            ix = e + 32768;
            rq = (ix & 255) << 4;
            poly = 65536 + rq + ((longint'(rq) * rq) >> 17);
            v = (ti[(ix >> 12) & 15] * tf[(ix >> 8) & 15]) >> 16;
            return (v * poly) >> 16;
        endfunction

        function void box_axis(logic [15:0] ac, logic [15:0] asz, logic [15:0] dc,
                               logic [15:0] ds, logic [15:0] vc, logic [15:0] vs,
                               logic [12:0] img_raw, output longint lo, output longint ext);
            longint img, cen, ew, sz, half, lim, pa, pb;
            img = (img_raw == 0) ? 1 : (img_raw > 4096 ? 4096 : img_raw);
            cen = longint'(ac) + fdiv(longint'(vc) * longint'($signed(dc)) * longint'(asz), 28);
            ew = fdiv(longint'(vs) * longint'($signed(ds)), 16);
            sz = (exp_fixed(ew) * longint'(asz)) >>> 16;
            half = sz >>> 1;
            lim = (img - 1) * 65536;
            pa = (cen - half) * img;
            pb = (cen + half) * img;
            if (pa > lim) pa = lim;
            if (pa < 0) pa = 0;
            if (pb > lim) pb = lim;
            if (pb < 0) pb = 0;
            lo = pa >>> 16;
            ext = ((pb - pa) >>> 16) + 1;
        endfunction

        function void note_request(logic mode, logic [159:0] d);
            detection_t r;
            longint lx, wx, ty, hy;
            int unsigned sc;
            if (mode == MODE_SCORE) begin
                sc = d[15:0];
                if (seen >= NUM_CLASSES_DEF) return;
                if (seen == 1 || (seen > 1 && sc > best_score)) begin
                    best_score = sc;
                    best_cls = seen - 1;
                end
                seen++;
                return;
            end
            r.best = 16'(best_score);
            r.cls = 7'(best_cls);
            seen = 0; best_score = 0; best_cls = 0;
            if (!(r.best > thresh)) return;
            box_axis(d[95:80], d[127:112], d[31:16], d[63:48], vcx, vw, imw, lx, wx);
            box_axis(d[111:96], d[143:128], d[47:32], d[79:64], vcy, vh, imh, ty, hy);
            r.lx = 12'(lx); r.ty = 12'(ty); r.bw = 13'(wx); r.bh = 13'(hy);
            r.idx = d[158:144];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [87:0] q);
            detection_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", q);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (q[6:0] !== e.cls) begin
                $error("class_id exp %0d got %0d", e.cls, q[6:0]); errors++;
            end
            if (q[22:7] !== e.best) begin
                $error("best_confidence exp %0d got %0d", e.best, q[22:7]); errors++;
            end
            if (q[34:23] !== e.lx) begin
                $error("left_x exp %0d got %0d", e.lx, q[34:23]); errors++;
            end
            if (q[46:35] !== e.ty) begin
                $error("top_y exp %0d got %0d", e.ty, q[46:35]); errors++;
            end
            if (q[59:47] !== e.bw) begin
                $error("box_width exp %0d got %0d", e.bw, q[59:47]); errors++;
            end
            if (q[72:60] !== e.bh) begin
                $error("box_height exp %0d got %0d", e.bh, q[72:60]); errors++;
            end
            if (q[87:73] !== e.idx) begin
                $error("source_index exp %0d got %0d", e.idx, q[87:73]); errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    detection_board board;
    int cycles;
    int hold_off;
    bit rx_random;
    int issued;

    prior_box_score_decode dut (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 900000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin
        int w;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off > 0) begin
                m_tready <= 0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end
            w = rx_random ? $urandom_range(0, 10) : 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            board.check_result(m_tdata);
        end
    end

    task automatic cfg_write(logic [2:0] a, logic [15:0] d);
        s_tvalid <= 0;
        cfg_we <= 1; cfg_addr <= a; cfg_wdata <= d;
        @(posedge aclk);
        board.write_reg(a, d);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // valid stays high after acceptance; the next gap or idle drops it
    task automatic send(logic mode, logic [159:0] d, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 10) : 0;
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= mode; s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(mode, d);
        issued++;
    endtask

    function automatic logic [159:0] rand_box(bit wide);
        logic [159:0] d;
        d = {$urandom, $urandom, $urandom, $urandom, $urandom};
        d[159] = 0;
        if (!wide) begin
            // keep boxes plausible most of the time
            d[31:16] = 16'($urandom_range(0, 8191) - 4096);
            d[47:32] = 16'($urandom_range(0, 8191) - 4096);
            d[63:48] = 16'($urandom_range(0, 8191) - 4096);
            d[79:64] = 16'($urandom_range(0, 8191) - 4096);
        end
        return d;
    endfunction

    // scores for one prior; n_scores may run short or long
    task automatic send_prior(int n_scores, int hi, bit wide, bit gaps);
        logic [159:0] d;
        for (int i = 0; i < n_scores; i++) begin
            d = rand_box(1);
            d[15:0] = 16'($urandom_range(0, hi));
            send(MODE_SCORE, d, gaps);
        end
        send(MODE_BOX, rand_box(wide), gaps);
    endtask

    initial begin
        logic [159:0] d;
        board = new();
        board.reset_state();
        hold_off = 0; rx_random = 1; issued = 0;
        aresetn = 0; cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, ties, short and long priors
        cfg_write(REG_THRESHOLD, 16'd0);
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d[15:0] = (i == 0) ? 16'hFFFF : 16'd100;
            send(MODE_SCORE, d, 0);
        end
        d = {1'b0, 15'h7FFF, {4{16'hFFFF}}, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0};
        send(MODE_BOX, d, 0);
        d = {1'b0, 15'd0, 64'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd0};
        send(MODE_SCORE, d, 0);
        d[15:0] = 16'hFFFF;
        send(MODE_SCORE, d, 0);
        send(MODE_BOX, d, 0);
        send(MODE_BOX, d, 0);
        send_prior(NUM_CLASSES_DEF + 3, 65535, 1, 0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            int n;
            case (phase)
                0: begin
                    cfg_write(REG_THRESHOLD, 16'd0);
                    for (int r = REG_VAR_CX; r <= REG_VAR_H; r++) cfg_write(3'(r), 16'hFFFF);
                    cfg_write(REG_IMG_W, 16'd4096); cfg_write(REG_IMG_H, 16'd4096);
                end
                1: begin
                    for (int r = REG_VAR_CX; r <= REG_VAR_H; r++) cfg_write(3'(r), 16'd0);
                    cfg_write(REG_IMG_W, 16'd1); cfg_write(REG_IMG_H, 16'd0);
                end
                2: begin
                    cfg_write(REG_THRESHOLD, 16'hFFFF);
                    cfg_write(REG_IMG_W, 16'h1FFF); cfg_write(REG_IMG_H, 16'd4097);
                end
                default: begin
                    cfg_write(REG_THRESHOLD, 16'($urandom_range(0, 40000)));
                    for (int r = REG_VAR_CX; r <= REG_VAR_H; r++)
                        cfg_write(3'(r), 16'($urandom));
                    cfg_write(REG_IMG_W, 16'($urandom_range(1, 4096)));
                    cfg_write(REG_IMG_H, 16'($urandom_range(1, 4096)));
                end
            endcase
            rx_random = (phase != 4);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 90) : NUM_CLASSES_DEF;
            send_prior(n, 65535, $urandom_range(0, 4) == 0, phase != 5);
            if (phase == 0) begin
                // hold the result side off while short priors keep arriving
                hold_off = 400;
                repeat (6) send_prior(3, 65535, 0, 1);
            end
            if (phase == 2) cfg_write(REG_THRESHOLD, 16'd1000);
            // sender pause until everything has come back
            s_tvalid <= 0;
            while (board.pending.size() != 0) @(posedge aclk);
            send_prior(3, 65535, 0, 1);
            drain();
        end
        while (issued < 750) send_prior(3, 65535, 0, 1);
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/pbsd_pkg.sv
hdl/pbsd_front.sv
hdl/pbsd_queue.sv
hdl/pbsd_back.sv
hdl/prior_box_score_decode.sv
dv/tb_prior_box_score_decode.sv
